// ----- rtl/core/pfde_pkg.sv -----
// shared constants for the page frame store draw engine
`default_nettype none
package pfde_pkg;
	localparam int Width = 133;
	localparam int Height = 64;
	localparam int StoreBytes = 1064;
	localparam int AW = 11;
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_SET = 3'd1;
	localparam logic [2:0] OP_GET = 3'd2;
	localparam logic [2:0] OP_LINE = 3'd3;
	localparam logic [2:0] OP_OUTLINE = 3'd4;
	localparam logic [2:0] OP_FILL = 3'd5;
	localparam logic [2:0] OP_COLUMN = 3'd6;
	localparam logic [2:0] OP_READ = 3'd7;
endpackage
`default_nettype wire

// ----- rtl/core/pfde_div.sv -----
// restoring divider for line minor offsets, one quotient bit a cycle
`default_nettype none
module pfde_div
	import pfde_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [15:0] num,
	input  wire logic [7:0]  den,
	output logic             done,
	output logic [7:0]       quo
);
	logic [15:0] n_q;
	logic [7:0]  r_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [8:0]  trial;
	assign trial = {r_q, n_q[15]} - {1'b0, den};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			n_q <= num;
			r_q <= '0;
		end else if (run_q) begin
			if (!trial[8]) begin
				r_q <= trial[7:0];
				n_q <= {n_q[14:0], 1'b1};
			end else begin
				r_q <= {r_q[6:0], n_q[15]};
				n_q <= {n_q[14:0], 1'b0};
			end
		end
	end
	assign quo = n_q[7:0];
endmodule
`default_nettype wire

// ----- rtl/core/page_framebuffer_draw_engine_top.sv -----
// top level of the page frame store draw engine
`default_nettype none
// Draw engine over a 1064-byte page organized monochrome frame store (133 x 64).
// A command is taken when start is high and busy low; its single result shows for
// one cycle with done high and cannot be stalled. Pixel and column writes are a
// read-modify-write through one memory (S_RD then S_WR); a line pixel first waits
// on the shared divider. Clear writes zeros without a read, one byte a cycle; after
// reset the same sweep runs before busy drops. Fill visits every pixel of the
// rectangle, and column merge works on three bytes.
module page_framebuffer_draw_engine_top
	import pfde_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  x0,
	input  wire logic [7:0]  y0,
	input  wire logic [7:0]  x1,
	input  wire logic [7:0]  y1,
	input  wire logic        pixel_color,
	input  wire logic [15:0] column_bits,
	input  wire logic [4:0]  column_height,
	input  wire logic [10:0] byte_addr,
	output logic             done,
	output logic             pixel_value,
	output logic [7:0]       byte_value
);
	localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_LSET = 4'd2, S_LDIV = 4'd3,
		S_LWAIT = 4'd4, S_PIX = 4'd5, S_RD = 4'd6, S_WR = 4'd7, S_NEXT = 4'd8,
		S_FIN = 4'd9, S_COL = 4'd10;
	logic [3:0] st_q;
	logic [2:0] op_q;
	logic [7:0] x0_q, y0_q, x1_q, y1_q;
	logic color_q;
	logic [15:0] cbits_q, cmask_q;
	logic [1:0] seg_q, colk_q;
	logic [7:0] la_x, la_y, lb_x, lb_y, k_q, maj_q, min_q;
	logic xmaj_q;
	logic [7:0] px_q, py_q;
	logic [10:0] addr_q;
	logic [7:0] wmask_q, wbits_q;
	logic [7:0] mem [StoreBytes];
	logic [7:0] rd_q;
	logic we;
	logic [7:0] wd;
	logic [10:0] clr_q;
	logic [7:0] fx_q;
	logic dgo, ddone;
	logic [7:0] dq;
	logic [7:0] sx, sy;
	logic [15:0] prod;
	logic [7:0] cur_x, cur_y;
	logic pin;
	logic [10:0] paddr;
	logic [12:0] caddr;
	logic [3:0] ret_q;
	logic [7:0] hi_x, hi_y;
	pfde_div u_div (.clk(clk), .arst_n(arst_n), .go(dgo), .num(prod), .den(maj_q),
		.done(ddone), .quo(dq));
	assign sx = (lb_x >= la_x) ? lb_x - la_x : la_x - lb_x;
	assign sy = (lb_y >= la_y) ? lb_y - la_y : la_y - lb_y;
	assign prod = k_q * min_q;
	assign dgo = (st_q == S_LDIV);
	assign busy = (st_q != S_IDLE);
	assign hi_x = (x0_q < x1_q) ? x1_q : x0_q;
	assign hi_y = (y0_q < y1_q) ? y1_q : y0_q;
	always_comb begin
		if (xmaj_q) begin
			cur_x = (lb_x >= la_x) ? la_x + k_q : la_x - k_q;
			cur_y = (lb_y >= la_y) ? la_y + dq : la_y - dq;
		end else begin
			cur_x = (lb_x >= la_x) ? la_x + dq : la_x - dq;
			cur_y = (lb_y >= la_y) ? la_y + k_q : la_y - k_q;
		end
	end
	assign pin = (px_q < 8'(Width)) && (py_q < 8'(Height));
	assign paddr = 11'(py_q[7:3]) * 11'(Width) + 11'(px_q);
	assign caddr = 13'(y0_q[7:3]) * 13'(Width) + 13'(x0_q) + 13'(x1_q)
		+ 13'(colk_q) * 13'(Width);
	assign we = (st_q == S_CLR) || (st_q == S_WR && addr_q < 11'(StoreBytes)
		&& op_q != OP_GET && op_q != OP_READ);
	assign wd = (st_q == S_CLR) ? 8'd0 : ((rd_q & ~wmask_q) | wbits_q);
	always_ff @(posedge clk) begin
		if (we) mem[(st_q == S_CLR) ? clr_q : addr_q] <= wd;
		rd_q <= mem[addr_q];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			done <= 1'b0;
			pixel_value <= 1'b0;
			byte_value <= '0;
			ret_q <= S_IDLE;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					op_q <= opcode; x0_q <= x0; y0_q <= y0; x1_q <= x1; y1_q <= y1;
					color_q <= pixel_color; cbits_q <= column_bits;
					cmask_q <= (column_height >= 5'd16) ? 16'hFFFF
						: 16'(16'hFFFF >> (5'd16 - column_height));
					seg_q <= '0; colk_q <= '0;
					unique case (opcode)
						OP_CLEAR: begin clr_q <= '0; ret_q <= S_FIN; st_q <= S_CLR; end
						OP_SET, OP_GET: begin
							px_q <= x0; py_q <= y0; ret_q <= S_FIN; st_q <= S_PIX;
						end
						OP_LINE, OP_OUTLINE: begin
							la_x <= x0; la_y <= y0; lb_y <= y1;
							lb_x <= (opcode == OP_OUTLINE) ? x0 : x1;
							st_q <= S_LSET;
						end
						OP_FILL: begin
							fx_q <= (x0 < x1) ? x0 : x1;
							px_q <= (x0 < x1) ? x0 : x1; py_q <= (y0 < y1) ? y0 : y1;
							ret_q <= S_NEXT; st_q <= S_PIX;
						end
						OP_COLUMN: st_q <= S_COL;
						default: begin addr_q <= byte_addr; st_q <= S_RD; end
					endcase
				end
				S_CLR: begin
					clr_q <= clr_q + 11'd1;
					if (clr_q == 11'(StoreBytes - 1)) st_q <= ret_q;
				end
				S_LSET: begin
					xmaj_q <= !(sx < sy);
					maj_q <= (sx < sy) ? sy : sx;
					min_q <= (sx < sy) ? sx : sy;
					k_q <= '0;
					st_q <= S_LDIV;
				end
				S_LDIV: st_q <= S_LWAIT;
				S_LWAIT: if (ddone || maj_q == 8'd0) begin
					px_q <= (maj_q == 8'd0) ? la_x : cur_x;
					py_q <= (maj_q == 8'd0) ? la_y : cur_y;
					ret_q <= S_NEXT; st_q <= S_PIX;
				end
				S_PIX: begin
					addr_q <= pin ? paddr : 11'(StoreBytes);
					wmask_q <= 8'd1 << py_q[2:0];
					wbits_q <= color_q ? (8'd1 << py_q[2:0]) : 8'd0;
					if (!pin && op_q != OP_GET) st_q <= ret_q;
					else st_q <= S_RD;
				end
				S_RD: st_q <= S_WR;
				S_WR: begin
					if (op_q == OP_GET) begin
						pixel_value <= (addr_q < 11'(StoreBytes)) & rd_q[py_q[2:0]];
						st_q <= S_FIN;
					end else if (op_q == OP_READ) begin
						byte_value <= (addr_q < 11'(StoreBytes)) ? rd_q : 8'd0;
						st_q <= S_FIN;
					end else st_q <= ret_q;
				end
				S_NEXT: begin
					if (op_q == OP_FILL) begin
						if (px_q != hi_x) begin px_q <= px_q + 8'd1; st_q <= S_PIX; end
						else if (py_q != hi_y) begin
							px_q <= fx_q; py_q <= py_q + 8'd1; st_q <= S_PIX;
						end else st_q <= S_FIN;
					end else if (op_q == OP_COLUMN) st_q <= S_COL;
					else if (k_q != maj_q) begin
						k_q <= k_q + 8'd1; st_q <= S_LDIV;
					end else if (op_q == OP_OUTLINE && seg_q != 2'd3) begin
						seg_q <= seg_q + 2'd1;
						unique case (seg_q)
							2'd0: begin la_x <= x0_q; la_y <= y0_q; lb_x <= x1_q; lb_y <= y0_q; end
							2'd1: begin la_x <= x0_q; la_y <= y1_q; lb_x <= x1_q; lb_y <= y1_q; end
							default: begin
								la_x <= x1_q; la_y <= y0_q; lb_x <= x1_q; lb_y <= y1_q;
							end
						endcase
						st_q <= S_LSET;
					end else st_q <= S_FIN;
				end
				S_COL: if (colk_q == 2'd3) st_q <= S_FIN;
				else begin
					addr_q <= (caddr < 13'(StoreBytes)) ? caddr[10:0] : 11'(StoreBytes);
					unique case (colk_q)
						2'd0: begin
							wmask_q <= 8'(cmask_q << y0_q[2:0]);
							wbits_q <= 8'(cbits_q << y0_q[2:0]);
						end
						2'd1: begin
							wmask_q <= 8'((24'(cmask_q) << y0_q[2:0]) >> 8);
							wbits_q <= 8'((24'(cbits_q) << y0_q[2:0]) >> 8);
						end
						default: begin
							wmask_q <= 8'((24'(cmask_q) << y0_q[2:0]) >> 16);
							wbits_q <= 8'((24'(cbits_q) << y0_q[2:0]) >> 16);
						end
					endcase
					colk_q <= colk_q + 2'd1;
					ret_q <= S_NEXT; st_q <= S_RD;
				end
				S_FIN: begin
					done <= 1'b1; st_q <= S_IDLE;
					if (op_q != OP_GET) pixel_value <= 1'b0;
					if (op_q != OP_READ) byte_value <= 8'd0;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("command not taken");
	a_pix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != OP_GET) |-> !pixel_value) else $error("stale pixel");
`endif
endmodule
`default_nettype wire
